// ----- hdl/dapce_pkg.sv -----
// ----------------------------------------------------------------------------
// dapce_pkg - shared types and constants
// Fixed-point formats, item structs, register indexes and saturation helper
// for the dual-axis PID cost evaluator.
// ----------------------------------------------------------------------------
package dapce_pkg;

  localparam int FRAC_BITS = 16;
  localparam int ACC_W     = 48;
  localparam int DT_W      = 16;
  localparam int ONE_SEC   = 1 << FRAC_BITS;

  localparam logic [DT_W-1:0] DT_MIN = DT_W'((ONE_SEC + 500) / 1000);
  localparam logic [DT_W-1:0] DT_MAX = DT_W'((ONE_SEC * 5 + 50) / 100);

  // divider: |33-bit difference| shifted up by the fraction bits
  localparam int DIV_NUM_W = 33 + FRAC_BITS;
  localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

  localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
  localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

  typedef enum logic [2:0] {
    REG_GAIN_P,
    REG_GAIN_I,
    REG_GAIN_D,
    REG_INTEGRAL_BOUND,
    REG_SPEED_BOUND,
    REG_WEIGHT_ERROR,
    REG_WEIGHT_SMOOTH,
    REG_WEIGHT_ENERGY
  } cfg_reg_t;

  localparam logic [30:0] INTEGRAL_BOUND_RST = 31'd1966080;
  localparam logic [30:0] SPEED_BOUND_RST    = 31'd11796480;
  localparam logic [19:0] WEIGHT_ERROR_RST   = 20'd65536;
  localparam logic [19:0] WEIGHT_SMOOTH_RST  = 20'd3277;
  localparam logic [19:0] WEIGHT_ENERGY_RST  = 20'd655;

  typedef struct packed {
    logic signed [31:0] pitch_target;
    logic signed [31:0] yaw_target;
    logic [DT_W-1:0]    step_time;
    logic               last;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] pitch_position;
    logic signed [31:0] yaw_position;
    logic [ACC_W-1:0]   weighted_cost;
    logic               run_done;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] gain_p;
    logic signed [31:0] gain_i;
    logic signed [31:0] gain_d;
    logic [30:0]        integral_bound;
    logic [30:0]        speed_bound;
  } lane_cfg_t;

  typedef struct packed {
    logic [19:0] weight_error;
    logic [19:0] weight_smooth;
    logic [19:0] weight_energy;
  } weight_cfg_t;

  typedef struct packed {
    logic signed [31:0] position;
    logic [32:0]        err_abs;
    logic [32:0]        smooth_abs;
    logic [31:0]        energy_abs;
  } lane_res_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > S32_MAX) r = 32'sh7FFFFFFF;
    else if (v < S32_MIN) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

// ----- hdl/dapce_div.sv -----
// ----------------------------------------------------------------------------
// dapce_div - serial divider
// Restoring division, one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module dapce_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [dapce_pkg::DIV_NUM_W-1:0]   num,
  input  logic                              neg,
  input  logic [dapce_pkg::DT_W-1:0]        den,
  output logic                              done,
  output logic signed [dapce_pkg::DIV_NUM_W:0] quo
);
  import dapce_pkg::*;

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_NUM_W-1:0] sh;
  logic [DT_W-1:0]      rem;
  logic [DT_W-1:0]      den_r;
  logic                 neg_r;
  logic [DT_W:0]        trial;
  logic                 fits;

  assign trial = {rem, sh[DIV_NUM_W-1]};
  assign fits  = trial >= {1'b0, den_r};
  assign quo   = neg_r ? -$signed({1'b0, sh}) : $signed({1'b0, sh});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= !start && busy && (cnt == DIV_CNT_W'(1));
      if (start) begin
        busy  <= 1'b1;
        cnt   <= DIV_CNT_W'(DIV_NUM_W);
        sh    <= num;
        rem   <= '0;
        den_r <= den;
        neg_r <= neg;
      end else if (busy) begin
        rem <= fits ? DT_W'(trial - {1'b0, den_r}) : trial[DT_W-1:0];
        sh  <= {sh[DIV_NUM_W-2:0], fits};
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

// ----- hdl/dapce_lane.sv -----
// ----------------------------------------------------------------------------
// dapce_lane - one axis PID lane
// Error, clamped integral, derivative, speed clamp, position and actual speed
// on a shared multiplier and a serial divider; holds the axis run state.
// ----------------------------------------------------------------------------
module dapce_lane (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic signed [31:0]          target,
  input  logic [dapce_pkg::DT_W-1:0]  dt,
  input  logic                        last,
  input  dapce_pkg::lane_cfg_t        cfg,
  output logic                        done,
  output dapce_pkg::lane_res_t        res
);
  import dapce_pkg::*;

  typedef enum logic [3:0] {
    L_IDLE, L_ERR, L_MI, L_INT, L_DDIV, L_M0, L_M1, L_M2, L_M3,
    L_SPD, L_MPOS, L_POS, L_VST, L_VDIV, L_COMMIT
  } lstate_t;

  lstate_t state;

  // run state
  logic signed [31:0] pos, integ, prev_err, prev_spd;
  logic               seen;

  // per-item working registers
  logic signed [31:0] target_r, err_r, integ_new, der_r, speed_r, newpos_r, spd_r;
  logic [DT_W-1:0]    dt_r;
  logic               last_r;
  logic signed [63:0] prod, acc;

  logic signed [31:0] mul_a, mul_b, dt_s;
  logic signed [63:0] dif, mag, isum, isat, ib, sb, pos_sum, e_d, s_d;
  logic               div_start, div_done;
  logic [DIV_NUM_W-1:0] div_num;
  logic signed [DIV_NUM_W:0] quo;

  assign dt_s = $signed({{(32-DT_W){1'b0}}, dt_r});
  assign ib   = 64'($signed({1'b0, cfg.integral_bound}));
  assign sb   = 64'($signed({1'b0, cfg.speed_bound}));

  always_comb begin
    case (state)
      L_MI:    begin mul_a = err_r;      mul_b = dt_s;       end
      L_M0:    begin mul_a = cfg.gain_p; mul_b = err_r;      end
      L_M1:    begin mul_a = cfg.gain_i; mul_b = integ_new;  end
      L_M2:    begin mul_a = cfg.gain_d; mul_b = der_r;      end
      L_MPOS:  begin mul_a = speed_r;    mul_b = dt_s;       end
      default: begin mul_a = '0;         mul_b = '0;         end
    endcase
  end

  // divider operand: derivative difference, or position change
  always_comb begin
    if (state == L_VST) dif = 64'(newpos_r) - 64'(pos);
    else dif = 64'(err_r) - 64'(prev_err);
    mag       = dif[63] ? -dif : dif;
    div_num   = {mag[32:0], {FRAC_BITS{1'b0}}};
    div_start = (state == L_INT && seen) || (state == L_VST);
  end

  assign isum    = 64'(integ) + (prod >>> FRAC_BITS);
  assign isat    = 64'(sat32(isum));
  assign pos_sum = 64'(pos) + (prod >>> FRAC_BITS);
  assign e_d     = 64'(target_r) - 64'(newpos_r);
  assign s_d     = 64'(spd_r) - 64'(prev_spd);

  dapce_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .neg   (dif[63]),
    .den   (dt_r),
    .done  (div_done),
    .quo   (quo)
  );

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (rst) begin
      state    <= L_IDLE;
      done     <= 1'b0;
      pos      <= '0;
      integ    <= '0;
      prev_err <= '0;
      prev_spd <= '0;
      seen     <= 1'b0;
    end else begin
      done <= (state == L_COMMIT);
      case (state)
        L_IDLE: begin
          if (start) begin
            target_r <= target;
            dt_r     <= dt;
            last_r   <= last;
            state    <= L_ERR;
          end
        end
        L_ERR: begin
          err_r <= sat32(64'(target_r) - 64'(pos));
          state <= L_MI;
        end
        L_MI: state <= L_INT;
        L_INT: begin
          if (isat > ib) integ_new <= ib[31:0];
          else if (isat < -ib) integ_new <= 32'(-ib);
          else integ_new <= isat[31:0];
          if (seen) begin
            state <= L_DDIV;
          end else begin
            der_r <= '0;
            state <= L_M0;
          end
        end
        L_DDIV: begin
          if (div_done) begin
            der_r <= sat32(64'(quo));
            state <= L_M0;
          end
        end
        L_M0: state <= L_M1;
        L_M1: begin
          acc   <= prod >>> FRAC_BITS;
          state <= L_M2;
        end
        L_M2: begin
          acc   <= acc + (prod >>> FRAC_BITS);
          state <= L_M3;
        end
        L_M3: begin
          acc   <= acc + (prod >>> FRAC_BITS);
          state <= L_SPD;
        end
        L_SPD: begin
          if (acc > sb) speed_r <= sb[31:0];
          else if (acc < -sb) speed_r <= -sb[31:0];
          else speed_r <= acc[31:0];
          state <= L_MPOS;
        end
        L_MPOS: state <= L_POS;
        L_POS: begin
          newpos_r <= sat32(pos_sum);
          state    <= L_VST;
        end
        L_VST: state <= L_VDIV;
        L_VDIV: begin
          if (div_done) begin
            spd_r <= sat32(64'(quo));
            state <= L_COMMIT;
          end
        end
        L_COMMIT: begin
          res.position   <= newpos_r;
          res.err_abs    <= e_d[63] ? 33'(-e_d) : e_d[32:0];
          res.smooth_abs <= s_d[63] ? 33'(-s_d) : s_d[32:0];
          res.energy_abs <= spd_r[31] ? 32'(-64'(spd_r)) : spd_r;
          state          <= L_IDLE;
          if (last_r) begin
            pos      <= '0;
            integ    <= '0;
            prev_err <= '0;
            prev_spd <= '0;
            seen     <= 1'b0;
          end else begin
            pos      <= newpos_r;
            integ    <= integ_new;
            prev_err <= err_r;
            prev_spd <= spd_r;
            seen     <= 1'b1;
          end
        end
        default: state <= L_IDLE;
      endcase
    end
  end

endmodule

// ----- hdl/dapce_merge.sv -----
// ----------------------------------------------------------------------------
// dapce_merge - lane merge and cost
// Sums both lanes, time-weights into the saturating totals and forms the
// weighted cost with one shared 20x32 multiplier.
// ----------------------------------------------------------------------------
module dapce_merge (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  dapce_pkg::lane_res_t          res0,
  input  dapce_pkg::lane_res_t          res1,
  input  logic [dapce_pkg::DT_W-1:0]    dt,
  input  logic                          last,
  input  dapce_pkg::weight_cfg_t        wcfg,
  output logic                          done,
  output logic [dapce_pkg::ACC_W-1:0]   cost
);
  import dapce_pkg::*;

  localparam int PE_W   = 34 + DT_W;
  localparam int MP_W   = 52;
  localparam int FULL_W = MP_W + 32;

  typedef enum logic [2:0] {
    M_IDLE, M_PROD, M_ACC, M_LO, M_HI, M_TERM, M_ADD
  } mstate_t;

  mstate_t state;

  logic [33:0]       esum, ssum, nsum;
  logic [DT_W-1:0]   dt_r;
  logic              last_r;
  logic [PE_W-1:0]   pe, ps, pn;
  logic [ACC_W-1:0]  err_tot, smo_tot, ene_tot, term;
  logic [MP_W-1:0]   plo, phi, mprod;
  logic [1:0]        k;
  logic [19:0]       wsel;
  logic [ACC_W-1:0]  tsel;
  logic [31:0]       opb;
  logic [FULL_W-1:0] full;

  function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] a,
                                               input logic [ACC_W-1:0] b);
    logic [ACC_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[ACC_W] ? '1 : s[ACC_W-1:0];
  endfunction

  always_comb begin
    case (k)
      2'd0:    begin wsel = wcfg.weight_error;  tsel = err_tot; end
      2'd1:    begin wsel = wcfg.weight_smooth; tsel = smo_tot; end
      2'd2:    begin wsel = wcfg.weight_energy; tsel = ene_tot; end
      default: begin wsel = '0;                 tsel = '0;      end
    endcase
    opb   = (state == M_LO) ? tsel[31:0] : 32'(tsel[ACC_W-1:32]);
    mprod = MP_W'(wsel * opb);
    full  = {phi, 32'b0} + FULL_W'(plo);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= M_IDLE;
      done    <= 1'b0;
      err_tot <= '0;
      smo_tot <= '0;
      ene_tot <= '0;
      k       <= '0;
    end else begin
      done <= (state == M_ADD) && (k == 2'd2);
      case (state)
        M_IDLE: begin
          if (start) begin
            esum   <= 34'(res0.err_abs) + 34'(res1.err_abs);
            ssum   <= 34'(res0.smooth_abs) + 34'(res1.smooth_abs);
            nsum   <= 34'(res0.energy_abs) + 34'(res1.energy_abs);
            dt_r   <= dt;
            last_r <= last;
            state  <= M_PROD;
          end
        end
        M_PROD: begin
          pe    <= esum * dt_r;
          ps    <= ssum * dt_r;
          pn    <= nsum * dt_r;
          state <= M_ACC;
        end
        M_ACC: begin
          err_tot <= sat_add(err_tot, ACC_W'(pe >> FRAC_BITS));
          smo_tot <= sat_add(smo_tot, ACC_W'(ps >> FRAC_BITS));
          ene_tot <= sat_add(ene_tot, ACC_W'(pn >> FRAC_BITS));
          cost    <= '0;
          k       <= '0;
          state   <= M_LO;
        end
        M_LO: begin
          plo   <= mprod;
          state <= M_HI;
        end
        M_HI: begin
          phi   <= mprod;
          state <= M_TERM;
        end
        M_TERM: begin
          term  <= ((full >> FRAC_BITS) >> ACC_W) != '0 ? '1
                   : ACC_W'(full >> FRAC_BITS);
          state <= M_ADD;
        end
        M_ADD: begin
          cost <= sat_add(cost, term);
          if (k == 2'd2) begin
            state <= M_IDLE;
            if (last_r) begin
              err_tot <= '0;
              smo_tot <= '0;
              ene_tot <= '0;
            end
          end else begin
            k     <= k + 1'b1;
            state <= M_LO;
          end
        end
        default: state <= M_IDLE;
      endcase
    end
  end

endmodule

// ----- hdl/dual_axis_pid_cost_evaluator_core.sv -----
// ----------------------------------------------------------------------------
// dual_axis_pid_cost_evaluator_core - dual-axis PID tracking cost
// Two PID lanes (pitch, yaw) with shared gains drive simulated positions;
// a merge stage keeps the time-weighted cost of the run.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel in_valid/in_stall/in_item: one item per sample (targets,
//    time step, last flag). The step is clamped to 66..3277 (Q0.16 s).
//  - Output channel out_valid/out_stall/out_item: one item per input item,
//    both positions and the running weighted cost, run_done = last.
//  - Config port cfg_write/cfg_index/cfg_data: write only while idle.
//  - Each lane spends two passes of its serial divider (one quotient bit
//    a cycle); on the first item of a run the derivative division is
//    skipped. The merge then forms the cost on its shared weight
//    multiplier.
//  - One item at a time: in_stall is high from acceptance until the result
//    is in the output register. A stalled result sits in that register while
//    the next item is already taken and worked on.
//  - After an item with last set, all run state (lanes and totals) clears;
//    registers keep their values.
//  - Reset (rst, synchronous) clears run state and loads register defaults.
// ----------------------------------------------------------------------------
module dual_axis_pid_cost_evaluator_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  dapce_pkg::in_item_t  in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output dapce_pkg::out_item_t out_item,
  input  logic                 cfg_write,
  input  logic [2:0]           cfg_index,
  input  logic [31:0]          cfg_data
);
  import dapce_pkg::*;

  typedef enum logic [1:0] {T_IDLE, T_LANE, T_MERGE, T_OUT} tstate_t;

  tstate_t     state;
  lane_cfg_t   lcfg;
  weight_cfg_t wcfg;

  logic            in_acc, out_free, out_load;
  logic [DT_W-1:0] dt_c, dt_r;
  logic            last_r;
  logic [1:0]      lane_done;
  lane_res_t       res0, res1;
  logic            merge_done;
  logic [ACC_W-1:0] cost;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = state != T_IDLE;
  assign out_free = !out_valid || !out_stall;
  // result ready (fresh from the merge or held back) and the register is free
  assign out_load = ((state == T_MERGE && merge_done) || state == T_OUT) && out_free;

  // clamp the time step into its legal range
  always_comb begin
    if (in_item.step_time < DT_MIN) dt_c = DT_MIN;
    else if (in_item.step_time > DT_MAX) dt_c = DT_MAX;
    else dt_c = in_item.step_time;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      lcfg.gain_p         <= '0;
      lcfg.gain_i         <= '0;
      lcfg.gain_d         <= '0;
      lcfg.integral_bound <= INTEGRAL_BOUND_RST;
      lcfg.speed_bound    <= SPEED_BOUND_RST;
      wcfg.weight_error   <= WEIGHT_ERROR_RST;
      wcfg.weight_smooth  <= WEIGHT_SMOOTH_RST;
      wcfg.weight_energy  <= WEIGHT_ENERGY_RST;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_GAIN_P:         lcfg.gain_p         <= cfg_data;
        REG_GAIN_I:         lcfg.gain_i         <= cfg_data;
        REG_GAIN_D:         lcfg.gain_d         <= cfg_data;
        REG_INTEGRAL_BOUND: lcfg.integral_bound <= cfg_data[30:0];
        REG_SPEED_BOUND:    lcfg.speed_bound    <= cfg_data[30:0];
        REG_WEIGHT_ERROR:   wcfg.weight_error   <= cfg_data[19:0];
        REG_WEIGHT_SMOOTH:  wcfg.weight_smooth  <= cfg_data[19:0];
        REG_WEIGHT_ENERGY:  wcfg.weight_energy  <= cfg_data[19:0];
        default: ;
      endcase
    end
  end

  // pitch lane
  dapce_lane u_lane_pitch (
    .clk    (clk),
    .rst    (rst),
    .start  (in_acc),
    .target (in_item.pitch_target),
    .dt     (dt_c),
    .last   (in_item.last),
    .cfg    (lcfg),
    .done   (lane_done[0]),
    .res    (res0)
  );

  // yaw lane
  dapce_lane u_lane_yaw (
    .clk    (clk),
    .rst    (rst),
    .start  (in_acc),
    .target (in_item.yaw_target),
    .dt     (dt_c),
    .last   (in_item.last),
    .cfg    (lcfg),
    .done   (lane_done[1]),
    .res    (res1)
  );

  // totals and cost
  dapce_merge u_merge (
    .clk   (clk),
    .rst   (rst),
    .start (lane_done[0]),
    .res0  (res0),
    .res1  (res1),
    .dt    (dt_r),
    .last  (last_r),
    .wcfg  (wcfg),
    .done  (merge_done),
    .cost  (cost)
  );

  // sequencing and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= T_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid               <= 1'b1;
        out_item.pitch_position <= res0.position;
        out_item.yaw_position   <= res1.position;
        out_item.weighted_cost  <= cost;
        out_item.run_done       <= last_r;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        T_IDLE: begin
          if (in_acc) begin
            dt_r   <= dt_c;
            last_r <= in_item.last;
            state  <= T_LANE;
          end
        end
        T_LANE: begin
          if (lane_done[0]) state <= T_MERGE;
        end
        T_MERGE, T_OUT: begin
          if (out_load) state <= T_IDLE;
          else if (merge_done || state == T_OUT) state <= T_OUT;
        end
        default: state <= T_IDLE;
      endcase
    end
  end

  // both lanes share one schedule
  a_lanes_lockstep: assert property (@(posedge clk) disable iff (rst)
    lane_done[0] == lane_done[1])
    else $error("lanes finished out of step");

  a_lane_done_state: assert property (@(posedge clk) disable iff (rst)
    lane_done[0] |-> state == T_LANE)
    else $error("lane result outside lane phase");

  a_merge_done_state: assert property (@(posedge clk) disable iff (rst)
    merge_done |-> state == T_MERGE)
    else $error("merge result outside merge phase");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> state == T_LANE && in_stall)
    else $error("accepted item did not start the lanes");

endmodule
